// ===== sv/tbca_pkg.sv =====
// -----------------------------------------------------------------------------
// Transport block CRC attach: shared types and constants
// CRC polynomials, remainder tables, sizes and the structs that link the
// register block, the CRC datapath and the top level.
// -----------------------------------------------------------------------------
package tbca_pkg;

   localparam int WORD_BITS    = 128;
   localparam int HALF_BITS    = 64;
   localparam int CRC_W        = 24;
   localparam int VEC_W        = WORD_BITS + CRC_W;
   localparam int BLOCK_BITS_W = 19;
   localparam int WC_W         = 13;
   localparam int REM_W        = 8;
   localparam int SHIFT_W      = 5;
   localparam int LIMIT_W      = 21;

   localparam logic [BLOCK_BITS_W-1:0] CRC16_LIMIT = 19'd3824;

   // full generator polynomials, x^16+x^12+x^5+1 and CRC24A
   localparam logic [CRC_W:0] CRC16_POLY = 25'd69665;
   localparam logic [CRC_W:0] CRC24_POLY = 25'd25578747;

   localparam logic [SHIFT_W-1:0] CRC16_BITS = 5'd16;
   localparam logic [SHIFT_W-1:0] CRC24_BITS = 5'd24;

   localparam logic [REM_W-1:0] FULL_WORD = 8'd128;

   typedef logic [VEC_W-1:0][CRC_W-1:0] pow_table_type;

   typedef struct packed {
      logic                  zero;
      logic                  wide24;
      logic [WC_W-1:0]       burst_m1;
      logic [REM_W-1:0]      rem;
   } cfg_type;

   typedef struct packed {
      logic [CRC_W-1:0]      crc;
      logic [WORD_BITS-1:0]  word;
      logic [CRC_W-1:0]      spill;
      logic                  has_spill;
   } crc_result_type;

   // x^i mod P for every bit position of the reduction vector
   function automatic pow_table_type build_pow(input logic [CRC_W:0] poly, input int wide);
      pow_table_type        tbl;
      logic [CRC_W-1:0]     r;
      logic [CRC_W-1:0]     mask;
      logic                 top;
      tbl  = '0;
      mask = CRC_W'((25'd1 << wide) - 25'd1);
      r    = CRC_W'(1);
      for (int i = 0; i < VEC_W; i++) begin
         tbl[i] = r;
         top    = r[wide-1];
         r      = (r << 1) & mask;
         if (top) begin
            r = r ^ (poly[CRC_W-1:0] & mask);
         end
      end
      return tbl;
   endfunction

   localparam pow_table_type POW16 = build_pow(CRC16_POLY, 16);
   localparam pow_table_type POW24 = build_pow(CRC24_POLY, 24);

endpackage

// ===== sv/tbca_csr.sv =====
// -----------------------------------------------------------------------------
// Transport block CRC attach: configuration registers
// APB write/read of block_bits, plus the per-block figures derived from it
// (word count, bits in the final word, CRC kind).
// -----------------------------------------------------------------------------
module tbca_csr
   import tbca_pkg::*;
#(
   parameter int MAX_WORDS = 4096
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [2:0]              csr_paddr,
   input  logic [31:0]             csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready,
   output cfg_type                 cfg,
   output logic                    cfg_write
);

   localparam logic [LIMIT_W-1:0] LIMIT = LIMIT_W'(MAX_WORDS * WORD_BITS);

   logic [BLOCK_BITS_W-1:0] block_bits_ff;
   logic [BLOCK_BITS_W-1:0] block_bits_in;
   logic [BLOCK_BITS_W-1:0] bits;
   logic [BLOCK_BITS_W-1:0] bits_m1;
   logic                    sel_block_bits;

   assign csr_pready     = 1'b1;
   assign sel_block_bits = (csr_paddr[2] == 1'b0);
   assign cfg_write      = csr_psel & csr_penable & csr_pwrite & csr_pready & sel_block_bits;

   always_comb begin
      block_bits_in = block_bits_ff;
      if (cfg_write) begin
         block_bits_in = csr_pwdata[BLOCK_BITS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_bits_ff <= BLOCK_BITS_W'(1);
      end else begin
         block_bits_ff <= block_bits_in;
      end
   end

   assign csr_prdata = sel_block_bits ? {{(32-BLOCK_BITS_W){1'b0}}, block_bits_ff} : 32'd0;

   // clip over-long blocks to the word budget
   always_comb begin
      bits = block_bits_ff;
      if ({{(LIMIT_W-BLOCK_BITS_W){1'b0}}, block_bits_ff} > LIMIT) begin
         bits = LIMIT[BLOCK_BITS_W-1:0];
      end
      bits_m1      = bits - BLOCK_BITS_W'(1);
      cfg.zero     = (bits == '0);
      cfg.wide24   = (bits > CRC16_LIMIT);
      cfg.burst_m1 = WC_W'(bits_m1[BLOCK_BITS_W-1:7]);
      cfg.rem      = {1'b0, bits_m1[6:0]} + REM_W'(1);
   end

endmodule

// ===== sv/tbca_crc_core.sv =====
// -----------------------------------------------------------------------------
// Transport block CRC attach: CRC and packing datapath
// Advances the CRC over the low rem bits of a word in one pass and packs the
// final word with the CRC, splitting off the bits that need a spill beat.
// -----------------------------------------------------------------------------
module tbca_crc_core
   import tbca_pkg::*;
(
   input  logic [WORD_BITS-1:0]   word,
   input  logic [CRC_W-1:0]       crc_in,
   input  logic [REM_W-1:0]       rem,
   input  logic                   wide24,
   output crc_result_type         result
);

   logic [WORD_BITS-1:0]  keep_mask;
   logic [WORD_BITS-1:0]  msg;
   logic [SHIFT_W-1:0]    wide_n;
   logic [VEC_W-1:0]      msg_up;
   logic [VEC_W-1:0]      vec;
   logic [CRC_W-1:0]      crc_new;
   logic [VEC_W-1:0]      packed_word;
   logic [REM_W-1:0]      gap;
   logic [SHIFT_W-1:0]    excess;

   assign keep_mask = ~({WORD_BITS{1'b1}} << rem);
   assign msg       = word & keep_mask;
   assign wide_n    = wide24 ? CRC24_BITS : CRC16_BITS;
   assign msg_up    = {{CRC_W{1'b0}}, msg} << wide_n;

   // state after rem bits is (crc * x^rem + msg * x^w) mod P
   assign vec = ({{WORD_BITS{1'b0}}, crc_in} << rem) ^ msg_up;

   always_comb begin
      crc_new = '0;
      for (int i = 0; i < VEC_W; i++) begin
         if (vec[i]) begin
            crc_new = crc_new ^ (wide24 ? POW24[i] : POW16[i]);
         end
      end
   end

   assign packed_word = msg_up | {{WORD_BITS{1'b0}}, crc_new};
   assign gap         = FULL_WORD - rem;

   // CRC bits that do not fit above the message move to the spill beat
   always_comb begin
      excess = '0;
      if (gap < {3'b000, wide_n}) begin
         excess = wide_n - gap[SHIFT_W-1:0];
      end
   end

   assign result.crc       = crc_new;
   assign result.word      = WORD_BITS'(packed_word >> excess);
   assign result.spill     = crc_new & ~({CRC_W{1'b1}} << excess);
   assign result.has_spill = (excess != '0);

endmodule

// ===== sv/transport_block_crc_attach_unit.sv =====
// -----------------------------------------------------------------------------
// Transport block CRC attach unit
// Passes transport block words through and appends a CRC16 or CRC24A.
// -----------------------------------------------------------------------------
// One block word is accepted per clock while the output is not stalled. Each
// word goes from the input register through a single-pass 128-bit CRC network
// into the output register, so the stream runs at one beat per cycle while
// rsp_tready stays high. The final word of a block takes two output beats when
// the CRC does not fit in its free high bits; the spill register holds the
// second beat and the input stalls until it moves to the output slot. block_bits
// sets the length of every block (clipped to MAX_WORDS words); a length of zero
// discards every input beat, and a write to block_bits restarts the block.
module transport_block_crc_attach_unit
   import tbca_pkg::*;
#(
   parameter int MAX_WORDS = 4096
) (
   input  logic            clock,
   input  logic            reset,
   // input beats
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic [127:0]    req_tdata,   // [63:0] data_hi, [127:64] data_lo
   // result beats
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output logic [127:0]    rsp_tdata,   // [63:0] out_hi, [127:64] out_lo
   output logic            rsp_tlast,
   // configuration
   input  logic            csr_psel,
   input  logic            csr_penable,
   input  logic            csr_pwrite,
   input  logic [2:0]      csr_paddr,
   input  logic [31:0]     csr_pwdata,
   output logic [31:0]     csr_prdata,
   output logic            csr_pready
);

   cfg_type               cfg;
   logic                  cfg_write;
   crc_result_type        core_out;

   logic                  a_valid_ff, a_valid_in;
   logic [HALF_BITS-1:0]  a_hi_ff, a_hi_in;
   logic [HALF_BITS-1:0]  a_lo_ff, a_lo_in;

   logic [CRC_W-1:0]      crc_ff, crc_in;
   logic [WC_W-1:0]       word_count_ff, word_count_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [HALF_BITS-1:0]  rsp_hi_ff, rsp_hi_in;
   logic [HALF_BITS-1:0]  rsp_lo_ff, rsp_lo_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  spill_valid_ff, spill_valid_in;
   logic [CRC_W-1:0]      spill_ff, spill_in;

   logic                  is_final;
   logic                  out_free;
   logic                  a_advance;
   logic                  a_emit;
   logic [REM_W-1:0]      rem_sel;

   tbca_csr #(
      .MAX_WORDS (MAX_WORDS)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .cfg_write   (cfg_write)
   );

   assign is_final = (word_count_ff >= cfg.burst_m1);
   assign rem_sel  = is_final ? cfg.rem : FULL_WORD;

   tbca_crc_core u_crc_core (
      .word   ({a_hi_ff, a_lo_ff}),
      .crc_in (crc_ff),
      .rem    (rem_sel),
      .wide24 (cfg.wide24),
      .result (core_out)
   );

   // output slot is free when empty or draining its last pending beat
   assign out_free   = !rsp_valid_ff || (rsp_tready && !spill_valid_ff);
   assign a_advance  = a_valid_ff && (cfg.zero || out_free);
   assign a_emit     = a_advance && !cfg.zero;
   assign req_tready = !a_valid_ff || a_advance;

   always_comb begin
      a_valid_in = a_valid_ff;
      a_hi_in    = a_hi_ff;
      a_lo_in    = a_lo_ff;
      if (a_advance) begin
         a_valid_in = 1'b0;
      end
      if (req_tvalid && req_tready) begin
         a_valid_in = 1'b1;
         a_hi_in    = req_tdata[63:0];
         a_lo_in    = req_tdata[127:64];
      end
   end

   always_comb begin
      crc_in        = crc_ff;
      word_count_in = word_count_ff;
      if (cfg_write) begin
         crc_in        = '0;
         word_count_in = '0;
      end else if (a_emit) begin
         if (is_final) begin
            crc_in        = '0;
            word_count_in = '0;
         end else begin
            crc_in        = core_out.crc;
            word_count_in = word_count_ff + WC_W'(1);
         end
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_hi_in      = rsp_hi_ff;
      rsp_lo_in      = rsp_lo_ff;
      rsp_last_in    = rsp_last_ff;
      spill_valid_in = spill_valid_ff;
      spill_in       = spill_ff;
      if (a_emit) begin
         rsp_valid_in   = 1'b1;
         spill_valid_in = is_final && core_out.has_spill;
         spill_in       = core_out.spill;
         rsp_last_in    = is_final && !core_out.has_spill;
         if (is_final) begin
            rsp_hi_in = core_out.word[127:64];
            rsp_lo_in = core_out.word[63:0];
         end else begin
            rsp_hi_in = a_hi_ff;
            rsp_lo_in = a_lo_ff;
         end
      end else if (rsp_valid_ff && rsp_tready) begin
         if (spill_valid_ff) begin
            // advance the spill beat into the output slot
            rsp_hi_in      = '0;
            rsp_lo_in      = {{(HALF_BITS-CRC_W){1'b0}}, spill_ff};
            rsp_last_in    = 1'b1;
            spill_valid_in = 1'b0;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff     <= 1'b0;
         crc_ff         <= '0;
         word_count_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
         spill_valid_ff <= 1'b0;
         rsp_last_ff    <= 1'b0;
      end else begin
         a_valid_ff     <= a_valid_in;
         crc_ff         <= crc_in;
         word_count_ff  <= word_count_in;
         rsp_valid_ff   <= rsp_valid_in;
         spill_valid_ff <= spill_valid_in;
         rsp_last_ff    <= rsp_last_in;
      end
   end

   always_ff @(posedge clock) begin
      a_hi_ff   <= a_hi_in;
      a_lo_ff   <= a_lo_in;
      rsp_hi_ff <= rsp_hi_in;
      rsp_lo_ff <= rsp_lo_in;
      spill_ff  <= spill_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_lo_ff, rsp_hi_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule
